// ----- hw/rtl/access_log_line_field_tagger_defines.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef ACCESS_LOG_LINE_FIELD_TAGGER_DEFINES_SVH
`define ACCESS_LOG_LINE_FIELD_TAGGER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lft_pkg.sv -----
`timescale 1ns / 1ps

package lft_pkg;

  localparam int unsigned TIME_BYTES = 8;
  localparam int unsigned LAST_FIELD = 6;

  localparam int unsigned FIELD_W      = 3;
  localparam int unsigned DATE_PHASE_W = 4;
  localparam int unsigned ACC_W        = 32;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FIELD_W-1:0] FIELD_CLIENT  = 3'd0;
  localparam logic [FIELD_W-1:0] FIELD_DATE    = 3'd3;
  localparam logic [FIELD_W-1:0] FIELD_REQUEST = 3'd4;
  localparam logic [FIELD_W-1:0] FIELD_STATUS  = 3'd5;
  localparam logic [FIELD_W-1:0] FIELD_SIZE    = 3'd6;
  localparam logic [FIELD_W-1:0] FIELD_MAX     = 3'd7;

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;

  localparam logic [ACC_W:0]   MAG_CAP = 33'h0_8000_0000;
  localparam logic [ACC_W-1:0] POS_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    TAG_NONE   = 3'd0,
    TAG_CLIENT = 3'd1,
    TAG_DATE   = 3'd2,
    TAG_TIME   = 3'd3,
    TAG_PATH   = 3'd4
  } tag_e;

  typedef enum logic [1:0] {
    NUM_LEAD   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_STOP   = 2'd2
  } num_phase_e;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_PATH  = 2'd1;
  localparam logic [1:0] REQ_DONE  = 2'd2;

  typedef struct packed {
    logic [7:0]       byte_out;
    tag_e             tag;
    logic             tag_restart;
    logic             line_done;
    logic [ACC_W-1:0] status_value;
    logic [ACC_W-1:0] size_value;
    logic             date_found;
    logic             path_found;
  } lft_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lft_q_status_t;

endpackage

// ----- hw/rtl/lft_front.sv -----
`timescale 1ns / 1ps

module lft_front
  import lft_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic [7:0]    s_byte_i,
  input  logic          s_last_i,
  input  lft_q_status_t q_status_i,
  output logic          push_o,
  output lft_item_t     push_item_o
);

  logic                    in_brackets_q, in_brackets_d, in_brackets_u;
  logic                    in_quotes_q, in_quotes_d, in_quotes_u;
  logic [FIELD_W-1:0]      field_q, field_d, field_u;
  logic [DATE_PHASE_W-1:0] date_phase_q, date_phase_d, date_phase_u;
  logic [1:0]              req_spaces_q, req_spaces_d, req_spaces_u;
  num_phase_e              num_phase_q, num_phase_d, num_phase_u;
  logic                    num_neg_q, num_neg_d, num_neg_u;
  logic [ACC_W-1:0]        status_acc_q, status_acc_d, status_acc_u;
  logic [ACC_W-1:0]        size_acc_q, size_acc_d, size_acc_u;
  logic [1:0]              found_q, found_d, found_u;

  logic [7:0] c;
  logic       is_lb, is_rb, is_qt, is_sp, is_colon, is_digit, is_ws;
  logic       active, sep;
  logic       nb, nq;

  logic [ACC_W-1:0]  acc_sel;
  logic [ACC_W+3:0]  acc_mul;
  logic [ACC_W-1:0]  fed_acc;
  num_phase_e        fed_phase;
  logic              fed_neg;
  tag_e              tag;
  logic              restart;

  function automatic logic [ACC_W-1:0] num_final(input logic [ACC_W-1:0] mag,
                                                 input logic neg);
    logic [ACC_W-1:0] r;
    if (neg) begin
      r = '0 - mag;
    end else if (mag[ACC_W-1]) begin
      r = POS_MAX;
    end else begin
      r = mag;
    end
    return r;
  endfunction

  assign c        = s_byte_i;
  assign is_lb    = (c == CH_LBRACKET);
  assign is_rb    = (c == CH_RBRACKET);
  assign is_qt    = (c == CH_QUOTE);
  assign is_sp    = (c == CH_SPACE);
  assign is_colon = (c == CH_COLON);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_ws    = is_sp || ((c >= CH_TAB) && (c <= CH_CR));

  assign s_ready_o = !q_status_i.full;
  assign push_o    = s_valid_i && s_ready_o;

  assign active = (field_q <= FIELD_W'(LAST_FIELD));
  assign nb     = is_lb ? 1'b1 : (is_rb ? 1'b0 : in_brackets_q);
  assign nq     = (!is_lb && !is_rb && is_qt) ? !in_quotes_q : in_quotes_q;
  assign sep    = active && !nb && !nq && is_sp;

  // Shared decimal accumulator for the status and size fields, magnitude capped at 2^31.
  assign acc_sel = (field_q == FIELD_STATUS) ? status_acc_q : size_acc_q;
  assign acc_mul = ({4'b0, acc_sel} << 3) + ({4'b0, acc_sel} << 1)
                 + (ACC_W + 4)'(c - CH_ZERO);

  always_comb begin
    fed_acc   = acc_sel;
    fed_phase = num_phase_q;
    fed_neg   = num_neg_q;
    unique case (num_phase_q)
      NUM_LEAD: begin
        if (is_ws) begin
          fed_phase = NUM_LEAD;
        end else if (c == CH_PLUS) begin
          fed_phase = NUM_DIGITS;
        end else if (c == CH_MINUS) begin
          fed_phase = NUM_DIGITS;
          fed_neg   = 1'b1;
        end else if (is_digit) begin
          fed_phase = NUM_DIGITS;
          fed_acc   = ACC_W'(c - CH_ZERO);
        end else begin
          fed_phase = NUM_STOP;
        end
      end
      NUM_DIGITS: begin
        if (is_digit) begin
          fed_acc = (acc_mul > (ACC_W + 4)'(MAG_CAP)) ? MAG_CAP[ACC_W-1:0]
                                                       : acc_mul[ACC_W-1:0];
        end else begin
          fed_phase = NUM_STOP;
        end
      end
      default: begin
        fed_phase = num_phase_q;
      end
    endcase
  end

  // State after this byte, before the end-of-line clear.
  always_comb begin
    in_brackets_u = in_brackets_q;
    in_quotes_u   = in_quotes_q;
    field_u       = field_q;
    date_phase_u  = date_phase_q;
    req_spaces_u  = req_spaces_q;
    num_phase_u   = num_phase_q;
    num_neg_u     = num_neg_q;
    status_acc_u  = status_acc_q;
    size_acc_u    = size_acc_q;
    found_u       = found_q;
    if (active) begin
      in_brackets_u = nb;
      in_quotes_u   = nq;
      if (sep) begin
        if (field_q == FIELD_STATUS) begin
          status_acc_u = num_final(status_acc_q, num_neg_q);
        end else if (field_q == FIELD_SIZE) begin
          size_acc_u = num_final(size_acc_q, num_neg_q);
        end
        if (field_q != FIELD_MAX) begin
          field_u = field_q + 1'b1;
        end
        num_phase_u = NUM_LEAD;
        num_neg_u   = 1'b0;
      end else begin
        unique case (field_q)
          FIELD_DATE: begin
            if (!found_q[0]) begin
              if (!is_lb && is_colon) begin
                found_u[0] = 1'b1;
              end
            end else if (date_phase_q < DATE_PHASE_W'(TIME_BYTES)) begin
              date_phase_u = date_phase_q + 1'b1;
            end
          end
          FIELD_REQUEST: begin
            if (req_spaces_q == REQ_START) begin
              if (is_sp) begin
                req_spaces_u = REQ_PATH;
              end
            end else if (req_spaces_q == REQ_PATH) begin
              if (!is_qt && is_sp) begin
                req_spaces_u = REQ_DONE;
                found_u[1]   = 1'b1;
              end
            end
          end
          FIELD_STATUS: begin
            status_acc_u = fed_acc;
            num_phase_u  = fed_phase;
            num_neg_u    = fed_neg;
          end
          FIELD_SIZE: begin
            size_acc_u  = fed_acc;
            num_phase_u = fed_phase;
            num_neg_u   = fed_neg;
          end
          default: begin
            field_u = field_q;
          end
        endcase
      end
    end
  end

  always_comb begin
    in_brackets_d = in_brackets_q;
    in_quotes_d   = in_quotes_q;
    field_d       = field_q;
    date_phase_d  = date_phase_q;
    req_spaces_d  = req_spaces_q;
    num_phase_d   = num_phase_q;
    num_neg_d     = num_neg_q;
    status_acc_d  = status_acc_q;
    size_acc_d    = size_acc_q;
    found_d       = found_q;
    if (push_o) begin
      if (s_last_i) begin
        in_brackets_d = 1'b0;
        in_quotes_d   = 1'b0;
        field_d       = '0;
        date_phase_d  = '0;
        req_spaces_d  = REQ_START;
        num_phase_d   = NUM_LEAD;
        num_neg_d     = 1'b0;
        status_acc_d  = '0;
        size_acc_d    = '0;
        found_d       = '0;
      end else begin
        in_brackets_d = in_brackets_u;
        in_quotes_d   = in_quotes_u;
        field_d       = field_u;
        date_phase_d  = date_phase_u;
        req_spaces_d  = req_spaces_u;
        num_phase_d   = num_phase_u;
        num_neg_d     = num_neg_u;
        status_acc_d  = status_acc_u;
        size_acc_d    = size_acc_u;
        found_d       = found_u;
      end
    end
  end

  // Region tag of this byte.
  always_comb begin
    tag     = TAG_NONE;
    restart = 1'b0;
    if (active && !sep) begin
      unique case (field_q)
        FIELD_CLIENT: begin
          tag = TAG_CLIENT;
        end
        FIELD_DATE: begin
          if (!found_q[0]) begin
            if (is_lb) begin
              tag     = TAG_DATE;
              restart = 1'b1;
            end else if (!is_colon) begin
              tag = TAG_DATE;
            end
          end else if (date_phase_q < DATE_PHASE_W'(TIME_BYTES)) begin
            tag = TAG_TIME;
          end
        end
        FIELD_REQUEST: begin
          if (req_spaces_q == REQ_PATH) begin
            if (is_qt) begin
              tag     = TAG_PATH;
              restart = 1'b1;
            end else if (!is_sp) begin
              tag = TAG_PATH;
            end
          end
        end
        default: begin
          tag = TAG_NONE;
        end
      endcase
    end
    // A line that ends inside the address leaves it empty.
    if (s_last_i && (field_u == FIELD_CLIENT)) begin
      tag     = TAG_CLIENT;
      restart = 1'b1;
    end
  end

  always_comb begin
    push_item_o              = '0;
    push_item_o.byte_out     = c;
    push_item_o.tag          = tag;
    push_item_o.tag_restart  = restart;
    push_item_o.line_done    = s_last_i;
    if (s_last_i) begin
      push_item_o.status_value = (field_u > FIELD_STATUS) ? status_acc_u : '0;
      if (field_u == FIELD_SIZE) begin
        push_item_o.size_value = num_final(size_acc_u, num_neg_u);
      end else if (field_u > FIELD_SIZE) begin
        push_item_o.size_value = size_acc_u;
      end
      push_item_o.date_found = found_u[0] && (field_u > FIELD_DATE);
      push_item_o.path_found = found_u[1] && (field_u > FIELD_REQUEST);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_brackets_q <= 1'b0;
      in_quotes_q   <= 1'b0;
      field_q       <= '0;
      date_phase_q  <= '0;
      req_spaces_q  <= REQ_START;
      num_phase_q   <= NUM_LEAD;
      num_neg_q     <= 1'b0;
      status_acc_q  <= '0;
      size_acc_q    <= '0;
      found_q       <= '0;
    end else begin
      in_brackets_q <= in_brackets_d;
      in_quotes_q   <= in_quotes_d;
      field_q       <= field_d;
      date_phase_q  <= date_phase_d;
      req_spaces_q  <= req_spaces_d;
      num_phase_q   <= num_phase_d;
      num_neg_q     <= num_neg_d;
      status_acc_q  <= status_acc_d;
      size_acc_q    <= size_acc_d;
      found_q       <= found_d;
    end
  end

endmodule

// ----- hw/rtl/lft_queue.sv -----
`timescale 1ns / 1ps

module lft_queue
  import lft_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lft_item_t     push_item_i,
  input  logic          pop_i,
  output lft_item_t     pop_item_o,
  output lft_q_status_t status_o
);

  lft_item_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_q, wptr_d;
  logic [QPTR_W-1:0]  rptr_q, rptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push, do_pop;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  assign pop_item_o = entry_q[rptr_q];

  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

// ----- hw/rtl/lft_back.sv -----
`timescale 1ns / 1ps

module lft_back
  import lft_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lft_q_status_t q_status_i,
  input  lft_item_t     q_item_i,
  output logic          pop_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic [79:0]   m_data_o,
  output logic [3:0]    m_user_o,
  output logic          m_last_o
);

  logic      valid_q, valid_d;
  lft_item_t item_q;

  // Refill the output register whenever it is empty or being drained.
  assign pop_o   = !q_status_i.empty && (!valid_q || m_ready_i);
  assign valid_d = pop_o ? 1'b1 : (m_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= q_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = {6'b0, item_q.path_found, item_q.date_found, item_q.size_value,
                      item_q.status_value, item_q.byte_out};
  assign m_user_o  = {item_q.tag_restart, item_q.tag};
  assign m_last_o  = item_q.line_done;

endmodule

// ----- hw/rtl/access_log_line_field_tagger.sv -----
// Data path: an accepted byte is written into the queue, then into the output register.
// Throughput: one byte per cycle while the queue has room, paced by the front-stage update.
// A four-beat queue and an output register let either side stall without holding the other.
// Reset: rst_ni is asynchronous and active low; it clears the parser state, the queue and
// the output valid. Parser state also returns to reset after each beat with tlast set.
`timescale 1ns / 1ps
`include "access_log_line_field_tagger_defines.svh"

module access_log_line_field_tagger
  import lft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  input  logic        s_axis_tlast_i,   // line_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] byte_out, [39:8] status_value, [71:40] size_value, [72] date_found,
  // [73] path_found, [79:74] zero
  output logic [79:0] m_axis_tdata_o,
  output logic [3:0]  m_axis_tuser_o,   // [2:0] tag, [3] tag_restart
  output logic        m_axis_tlast_o    // line_done
);

  lft_q_status_t q_status;
  lft_item_t     push_item;
  lft_item_t     pop_item;
  logic          push;
  logic          pop;

  lft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_byte_i    (s_axis_tdata_i),
    .s_last_i    (s_axis_tlast_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_item_o (push_item)
  );

  lft_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  lft_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_item_i   (pop_item),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_data_o   (m_axis_tdata_o),
    .m_user_o   (m_axis_tuser_o),
    .m_last_o   (m_axis_tlast_o)
  );

  `LFT_ASSERT_NOW(a_mid_line_no_values, m_axis_tvalid_o && !m_axis_tlast_o, m_axis_tdata_o[73:8] == '0, "line values set on a beat that does not end a line")
  `LFT_ASSERT_NOW(a_restart_has_region, m_axis_tvalid_o && m_axis_tuser_o[3], m_axis_tuser_o[2:0] == TAG_CLIENT || m_axis_tuser_o[2:0] == TAG_DATE || m_axis_tuser_o[2:0] == TAG_PATH, "restart flag on a beat outside a restartable region")
  `LFT_ASSERT_NEXT(a_queue_fill, push && !pop && !q_status.full, !q_status.empty, "queue empty after a push")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import lft_pkg::*;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        s_last  = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [79:0] m_data;
  logic [3:0]  m_user;
  logic        m_last;

  access_log_line_field_tagger i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always #1 clk_i = ~clk_i;

  // Predicted parser state
  logic                    in_br, in_qt;
  logic [FIELD_W-1:0]      field_idx;
  logic [DATE_PHASE_W-1:0] time_taken;
  logic [1:0]              req_state;
  num_phase_e              num_phase;
  logic                    num_neg;
  logic [ACC_W-1:0]        status_mag, size_mag;
  logic                    date_colon, path_seen;

  lft_item_t   tagged_beats[$];
  logic [7:0]  line_q[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          recv_hold_left = 0;
  string       token_chars = "abcdefghijklmnopqrstuvwxyzGET0123456789./-_%?=&";

  function automatic void clear_parser();
    in_br      = 1'b0;
    in_qt      = 1'b0;
    field_idx  = FIELD_CLIENT;
    time_taken = '0;
    req_state  = REQ_START;
    num_phase  = NUM_LEAD;
    num_neg    = 1'b0;
    status_mag = '0;
    size_mag   = '0;
    date_colon = 1'b0;
    path_seen  = 1'b0;
  endfunction

  // One character of an atoi-style decimal conversion; returns the updated magnitude.
  function automatic logic [ACC_W-1:0] atoi_step(input logic [ACC_W-1:0] mag,
                                                 input logic [7:0] ch);
    logic       digit;
    logic       blank;
    logic [63:0] v;
    digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    if (num_phase == NUM_LEAD) begin
      if (blank) return mag;
      if (ch == CH_PLUS) begin
        num_phase = NUM_DIGITS;
      end else if (ch == CH_MINUS) begin
        num_neg   = 1'b1;
        num_phase = NUM_DIGITS;
      end else if (digit) begin
        mag       = 32'(ch - CH_ZERO);
        num_phase = NUM_DIGITS;
      end else begin
        num_phase = NUM_STOP;
      end
    end else if (num_phase == NUM_DIGITS) begin
      if (digit) begin
        v = 64'(mag) * 64'd10 + 64'(ch - CH_ZERO);
        if (v > 64'(MAG_CAP)) v = 64'(MAG_CAP);
        mag = v[ACC_W-1:0];
      end else begin
        num_phase = NUM_STOP;
      end
    end
    return mag;
  endfunction

  function automatic logic [ACC_W-1:0] signed_value(input logic [ACC_W-1:0] mag);
    if (num_neg) return 32'd0 - mag;
    return (mag > POS_MAX) ? POS_MAX : mag;
  endfunction

  function automatic lft_item_t tag_byte(input logic [7:0] ch, input logic eol);
    lft_item_t r;
    r = '0;
    r.byte_out  = ch;
    r.tag       = TAG_NONE;
    r.line_done = eol;
    if (field_idx <= LAST_FIELD) begin
      if (ch == CH_LBRACKET) in_br = 1'b1;
      else if (ch == CH_RBRACKET) in_br = 1'b0;
      else if (ch == CH_QUOTE) in_qt = ~in_qt;

      if (!in_br && !in_qt && ch == CH_SPACE) begin
        // close the field; numeric fields turn into their signed value here
        if (field_idx == FIELD_STATUS) status_mag = signed_value(status_mag);
        else if (field_idx == FIELD_SIZE) size_mag = signed_value(size_mag);
        if (field_idx < FIELD_MAX) field_idx = field_idx + 1'b1;
        num_phase = NUM_LEAD;
        num_neg   = 1'b0;
      end else begin
        case (field_idx)
          FIELD_CLIENT: r.tag = TAG_CLIENT;
          FIELD_DATE: begin
            if (!date_colon) begin
              if (ch == CH_LBRACKET) begin
                r.tag         = TAG_DATE;
                r.tag_restart = 1'b1;
              end else if (ch == CH_COLON) begin
                date_colon = 1'b1;
              end else begin
                r.tag = TAG_DATE;
              end
            end else if (time_taken < TIME_BYTES) begin
              r.tag      = TAG_TIME;
              time_taken = time_taken + 1'b1;
            end
          end
          FIELD_REQUEST: begin
            if (req_state == REQ_START) begin
              if (ch == CH_SPACE) req_state = REQ_PATH;
            end else if (req_state == REQ_PATH) begin
              if (ch == CH_QUOTE) begin
                r.tag         = TAG_PATH;
                r.tag_restart = 1'b1;
              end else if (ch == CH_SPACE) begin
                req_state = REQ_DONE;
                path_seen = 1'b1;
              end else begin
                r.tag = TAG_PATH;
              end
            end
          end
          FIELD_STATUS: status_mag = atoi_step(status_mag, ch);
          FIELD_SIZE:   size_mag   = atoi_step(size_mag, ch);
          default: ;
        endcase
      end
    end

    if (eol) begin
      if (field_idx == FIELD_CLIENT) begin
        r.tag         = TAG_CLIENT;
        r.tag_restart = 1'b1;
      end
      r.status_value = (field_idx > FIELD_STATUS) ? status_mag : '0;
      if (field_idx == FIELD_SIZE) r.size_value = signed_value(size_mag);
      else if (field_idx > FIELD_SIZE) r.size_value = size_mag;
      r.date_found = date_colon && (field_idx > FIELD_DATE);
      r.path_found = path_seen && (field_idx > FIELD_REQUEST);
      clear_parser();
    end
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= ch;
    s_last  <= eol;
    do @(posedge clk_i); while (!s_ready);
    tagged_beats.push_back(tag_byte(ch, eol));
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
  endtask

  // Lower valid and hold until every tagged beat has come back.
  task automatic drain_results();
    s_valid <= 1'b0;
    while (tagged_beats.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_beat();
    lft_item_t want;
    if (tagged_beats.size() == 0) begin
      $display("%0t: unexpected beat: actual data %h user %h", $time, m_data, m_user);
      errors++;
      return;
    end
    want = tagged_beats.pop_front();
    report_field("byte_out", want.byte_out, m_data[7:0]);
    report_field("tag", want.tag, m_user[2:0]);
    report_field("tag_restart", want.tag_restart, m_user[3]);
    report_field("line_done", want.line_done, m_last);
    report_field("status_value", want.status_value, m_data[39:8]);
    report_field("size_value", want.size_value, m_data[71:40]);
    report_field("date_found", want.date_found, m_data[72]);
    report_field("path_found", want.path_found, m_data[73]);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) check_beat();
    if (recv_hold_left > 0) begin
      recv_hold_left <= recv_hold_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic push_token(input int max_len);
    int n;
    n = $urandom_range(max_len);
    repeat (n) line_q.push_back(token_chars[$urandom_range(token_chars.len() - 1)]);
  endtask

  function automatic string number_text();
    string s;
    case ($urandom_range(9))
      0: s = "";
      1, 2, 3: s = $sformatf("%0d", $urandom_range(999));
      4: s = $sformatf("%0d%05d", $urandom_range(99999, 10000), $urandom_range(99999));
      5: begin
        case ($urandom_range(2))
          0: s = "2147483647";
          1: s = "2147483648";
          default: s = "2147483649";
        endcase
      end
      6: s = $sformatf("%0d%09d%09d", $urandom_range(9, 1), $urandom_range(999999999),
                       $urandom_range(999999999));
      7: s = $sformatf("%0d", $urandom);
      8: s = "x12";
      default: s = "007";
    endcase
    case ($urandom_range(7))
      0: s = {"-", s};
      1: s = {"+", s};
      2: s = {"\t", s};
      3: s = {"\t-", s};
      default: ;
    endcase
    if ($urandom_range(9) == 0) s = {s, "z9"};
    return s;
  endfunction

  // Random but well-formed log line with random content; some are cut short.
  task automatic build_log_line();
    int keep;
    line_q.delete();
    push_token(8);
    push_text(" ");
    push_token(2);
    push_text(" ");
    push_token(3);
    push_text(" [");
    if ($urandom_range(7) == 0) begin
      push_token(3);
      push_text("[");
    end
    push_token(11);
    if ($urandom_range(7) != 0) begin
      push_text(":");
      push_token(14);
      if ($urandom_range(4) == 0) push_text(" +0000");
    end
    push_text("] \"");
    push_token(5);
    if ($urandom_range(7) != 0) begin
      push_text(" ");
      push_token(12);
      if ($urandom_range(11) == 0) begin
        push_text("\"");
        push_token(3);
      end
      if ($urandom_range(7) != 0) begin
        push_text(" ");
        push_token(8);
      end
    end
    push_text("\" ");
    push_text(number_text());
    push_text(" ");
    if ($urandom_range(2) == 0) push_text("-");
    else push_text(number_text());
    if ($urandom_range(4) == 0) begin
      push_text(" ");
      push_token(10);
    end
    if ($urandom_range(9) == 0) begin
      keep = $urandom_range(line_q.size(), 1);
      while (line_q.size() > keep) void'(line_q.pop_back());
    end
    if (line_q.size() == 0) push_text("x");
  endtask

  task automatic build_noise_line();
    int n;
    line_q.delete();
    n = $urandom_range(30, 1);
    repeat (n) begin
      case ($urandom_range(7))
        0: line_q.push_back(CH_LBRACKET);
        1: line_q.push_back(CH_RBRACKET);
        2: line_q.push_back(CH_QUOTE);
        3: line_q.push_back(CH_SPACE);
        4: line_q.push_back(CH_COLON);
        default: line_q.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic send_random_lines(input int byte_goal);
    int sent;
    sent = 0;
    while (sent < byte_goal) begin
      if ($urandom_range(99) < 85) build_log_line();
      else build_noise_line();
      send_line();
      sent += line_q.size();
    end
  endtask

  // Lines ending inside the client address, plus null and all-ones bytes.
  task automatic test_short_lines();
    line_q.delete();
    push_text("ab");
    send_line();
    line_q.delete();
    line_q.push_back(8'h00);
    send_line();
    line_q.delete();
    line_q.push_back(8'hFF);
    send_line();
    drain_results();
  endtask

  // Empty leading fields, a restarted date, a path, a signed status, a dash size.
  task automatic test_compact_line();
    line_q.delete();
    push_text("   [x[:t] \" / \" +7 -");
    send_line();
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold_left = 200;
    send_random_lines(60);
    drain_results();
  endtask

  task automatic test_random_traffic();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_lines(310);
    drain_results();
    send_idle_pct = 56;
    send_random_lines(310);
    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 56;
    send_random_lines(310);
    drain_results();
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    send_random_lines(310);
    drain_results();
  endtask

  initial begin
    clear_parser();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_lines();
    test_compact_line();
    test_backpressure();
    test_random_traffic();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
